// ----- design/arm_subset_instruction_executor_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file of the executor.
// ----------------------------------------------------------------------------
`ifndef ARM_SUBSET_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define ARM_SUBSET_INSTRUCTION_EXECUTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASIE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASIE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/asie_pkg.sv -----
// ----------------------------------------------------------------------------
// asie_pkg
// Types, codes and word layout shared by the instruction executor modules.
// ----------------------------------------------------------------------------
package asie_pkg;

  localparam int unsigned REG_COUNT = 16;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned XLEN      = 32;

  localparam logic [IDX_W-1:0] SP_IDX = 4'd13;
  localparam logic [IDX_W-1:0] LR_IDX = 4'd14;
  localparam logic [IDX_W-1:0] PC_IDX = 4'd15;

  // Input word kinds
  typedef enum logic [1:0] {
    REQ_INSTR = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_START = 2'd2
  } req_type_e;

  // Memory request kinds
  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_LOAD  = 2'd1,
    MEM_STORE = 2'd2
  } mem_req_e;

  // Data-processing opcodes
  localparam logic [3:0] OP_SUB = 4'h2;
  localparam logic [3:0] OP_ADD = 4'h4;
  localparam logic [3:0] OP_CMP = 4'hA;
  localparam logic [3:0] OP_MOV = 4'hD;

  // Branch condition codes
  localparam logic [3:0] COND_EQ = 4'h0;
  localparam logic [3:0] COND_NE = 4'h1;
  localparam logic [3:0] COND_GE = 4'hA;
  localparam logic [3:0] COND_LT = 4'hB;
  localparam logic [3:0] COND_GT = 4'hC;
  localparam logic [3:0] COND_LE = 4'hD;
  localparam logic [3:0] COND_AL = 4'hE;

  localparam logic [23:0] BX_PATTERN   = 24'h12FFF1;
  localparam logic [2:0]  BRANCH_CLASS = 3'b101;
  localparam logic [1:0]  CLS_DP       = 2'd0;
  localparam logic [1:0]  CLS_LS       = 2'd1;

  // Result word layout on the master tdata bus
  localparam int unsigned OUT_PC_LSB    = 0;
  localparam int unsigned OUT_ADDR_LSB  = 32;
  localparam int unsigned OUT_SDATA_LSB = 64;
  localparam int unsigned OUT_FLAGS_LSB = 96;
  localparam int unsigned OUT_DONE_BIT  = 100;
  localparam int unsigned OUT_FAULT_BIT = 101;
  localparam int unsigned OUT_RET_LSB   = 102;
  localparam int unsigned OUT_TDATA_W   = 136;

  typedef struct packed {
    logic [XLEN-1:0] entry_pc;
    logic [XLEN-1:0] arg_zero;
    logic [XLEN-1:0] arg_one;
    logic [XLEN-1:0] arg_two;
    logic [XLEN-1:0] arg_three;
    logic [XLEN-1:0] stack_top;
  } cfg_t;

  // Register file write: one general port plus a dedicated PC port.
  typedef struct packed {
    logic             gp_we;
    logic [IDX_W-1:0] gp_idx;
    logic [XLEN-1:0]  gp_data;
    logic             pc_we;
    logic [XLEN-1:0]  pc_data;
  } rf_wr_t;

  typedef struct packed {
    logic [XLEN-1:0] next_pc;
    mem_req_e        mem_req;
    logic [XLEN-1:0] mem_addr;
    logic [XLEN-1:0] store_data;
    logic [3:0]      flags;
    logic            fault;
    logic [XLEN-1:0] ret_val;
  } result_t;

endpackage

// ----- design/arm_subset_instruction_executor.sv -----
// A word accepted on the input side is held in the input register, which
// feeds the execute logic; that logic loads the result register and updates
// the architectural state in the same cycle. Throughput: one word per cycle,
// limited by the single execute pass, while the result stream does not stall.
// Reset: asynchronous, active low; clears registers r0-r15, flags, the pending
// load, the configuration registers and both pipeline valid bits.
// ----------------------------------------------------------------------------
// arm_subset_instruction_executor
// Executes a subset of 32-bit ARM instructions on a stream of words, with an
// APB-style port for the start values.
// ----------------------------------------------------------------------------
module arm_subset_instruction_executor #(
  parameter int unsigned RegCount = asie_pkg::REG_COUNT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [31:0]                        s_axis_tdata,  // data_word
  input  logic [1:0]                         s_axis_tuser,  // req_type
  // Result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // next_pc, mem_addr, store_data, flag_bits, done_res, fault, return_value,
  // two zero pad bits
  output logic [asie_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic [1:0]                         m_axis_tuser,  // mem_request
  // Configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [4:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import asie_pkg::*;

  localparam logic [2:0] RegEntryPc  = 3'd0;
  localparam logic [2:0] RegArgZero  = 3'd1;
  localparam logic [2:0] RegArgOne   = 3'd2;
  localparam logic [2:0] RegArgTwo   = 3'd3;
  localparam logic [2:0] RegArgThree = 3'd4;
  localparam logic [2:0] RegStackTop = 3'd5;
  localparam int unsigned IdxW = $clog2(RegCount);

  cfg_t             cfg_q;
  logic             in_vld_q;
  logic [1:0]       in_req_q;
  logic [XLEN-1:0]  in_word_q;
  logic             out_vld_q;
  result_t          out_q;
  logic [3:0]       flags_q;
  logic [3:0]       flags_d;
  logic             load_pend_q;
  logic             load_pend_d;
  logic [IDX_W-1:0] load_dest_q;
  logic [IDX_W-1:0] load_dest_d;
  logic             advance;
  logic             cfg_wr;
  rf_wr_t           ex_wr;
  rf_wr_t           rf_wr;
  result_t          ex_res;
  logic [XLEN-1:0]  rn_val;
  logic [XLEN-1:0]  rm_val;
  logic [XLEN-1:0]  rd_val;
  logic [XLEN-1:0]  pc_val;
  logic [XLEN-1:0]  r0_val;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[4:2])
      RegEntryPc:  prdata = cfg_q.entry_pc;
      RegArgZero:  prdata = cfg_q.arg_zero;
      RegArgOne:   prdata = cfg_q.arg_one;
      RegArgTwo:   prdata = cfg_q.arg_two;
      RegArgThree: prdata = cfg_q.arg_three;
      RegStackTop: prdata = cfg_q.stack_top;
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        RegEntryPc:  cfg_q.entry_pc  <= pwdata;
        RegArgZero:  cfg_q.arg_zero  <= pwdata;
        RegArgOne:   cfg_q.arg_one   <= pwdata;
        RegArgTwo:   cfg_q.arg_two   <= pwdata;
        RegArgThree: cfg_q.arg_three <= pwdata;
        RegStackTop: cfg_q.stack_top <= pwdata;
        default: ;
      endcase
    end
  end

  // The execute stage moves whenever the result register is free or drains.
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_req_q  <= s_axis_tuser;
      in_word_q <= s_axis_tdata;
    end
  end

  asie_regfile #(
    .RegCount (RegCount)
  ) u_regfile (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (advance && (req_type_e'(in_req_q) == REQ_START)),
    .cfg_i    (cfg_q),
    .wr_i     (rf_wr),
    .rn_idx_i (IdxW'(in_word_q[19:16])),
    .rm_idx_i (IdxW'(in_word_q[3:0])),
    .rd_idx_i (IdxW'(in_word_q[15:12])),
    .rn_val_o (rn_val),
    .rm_val_o (rm_val),
    .rd_val_o (rd_val),
    .pc_o     (pc_val),
    .r0_o     (r0_val)
  );

  asie_exec u_exec (
    .req_i       (in_req_q),
    .word_i      (in_word_q),
    .cfg_i       (cfg_q),
    .rn_val_i    (rn_val),
    .rm_val_i    (rm_val),
    .rd_val_i    (rd_val),
    .pc_i        (pc_val),
    .r0_i        (r0_val),
    .flags_i     (flags_q),
    .load_pend_i (load_pend_q),
    .load_dest_i (load_dest_q),
    .wr_o        (ex_wr),
    .flags_o     (flags_d),
    .load_pend_o (load_pend_d),
    .load_dest_o (load_dest_d),
    .res_o       (ex_res)
  );

  always_comb begin
    rf_wr       = ex_wr;
    rf_wr.gp_we = ex_wr.gp_we && advance;
    rf_wr.pc_we = ex_wr.pc_we && advance;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      load_pend_q <= 1'b0;
      load_dest_q <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      if (advance) begin
        flags_q     <= flags_d;
        load_pend_q <= load_pend_d;
        load_dest_q <= load_dest_d;
        out_vld_q   <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= ex_res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.mem_req;
  assign m_axis_tdata  = {2'b00, out_q.ret_val, out_q.fault, (out_q.next_pc == '0),
                          out_q.flags, out_q.store_data, out_q.mem_addr, out_q.next_pc};

endmodule

// ----- design/asie_regfile.sv -----
// ----------------------------------------------------------------------------
// asie_regfile
// Flip-flop register file with three indexed read ports plus PC and r0 reads,
// general and PC write ports and a start load that initializes every entry.
// ----------------------------------------------------------------------------
module asie_regfile #(
  parameter int unsigned RegCount = asie_pkg::REG_COUNT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  asie_pkg::cfg_t                    cfg_i,
  input  asie_pkg::rf_wr_t                  wr_i,
  input  logic [$clog2(RegCount)-1:0]       rn_idx_i,
  input  logic [$clog2(RegCount)-1:0]       rm_idx_i,
  input  logic [$clog2(RegCount)-1:0]       rd_idx_i,
  output logic [asie_pkg::XLEN-1:0]         rn_val_o,
  output logic [asie_pkg::XLEN-1:0]         rm_val_o,
  output logic [asie_pkg::XLEN-1:0]         rd_val_o,
  output logic [asie_pkg::XLEN-1:0]         pc_o,
  output logic [asie_pkg::XLEN-1:0]         r0_o
);
  import asie_pkg::*;

  localparam int unsigned IdxW = $clog2(RegCount);

  logic [XLEN-1:0] regs_q [RegCount];
  logic [XLEN-1:0] regs_d [RegCount];

  always_comb begin
    for (int i = 0; i < RegCount; i++) begin
      if (start_i) begin
        case (IdxW'(i))
          IdxW'(0):         regs_d[i] = cfg_i.arg_zero;
          IdxW'(1):         regs_d[i] = cfg_i.arg_one;
          IdxW'(2):         regs_d[i] = cfg_i.arg_two;
          IdxW'(3):         regs_d[i] = cfg_i.arg_three;
          IdxW'(SP_IDX):    regs_d[i] = cfg_i.stack_top;
          IdxW'(PC_IDX):    regs_d[i] = cfg_i.entry_pc;
          default:          regs_d[i] = '0;
        endcase
      end else if (wr_i.pc_we && (IdxW'(i) == IdxW'(PC_IDX))) begin
        regs_d[i] = wr_i.pc_data;
      end else if (wr_i.gp_we && (IdxW'(i) == IdxW'(wr_i.gp_idx))) begin
        regs_d[i] = wr_i.gp_data;
      end else begin
        regs_d[i] = regs_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RegCount; i++) regs_q[i] <= '0;
    end else begin
      for (int i = 0; i < RegCount; i++) regs_q[i] <= regs_d[i];
    end
  end

  assign rn_val_o = regs_q[rn_idx_i];
  assign rm_val_o = regs_q[rm_idx_i];
  assign rd_val_o = regs_q[rd_idx_i];
  assign pc_o     = regs_q[IdxW'(PC_IDX)];
  assign r0_o     = regs_q[0];

endmodule

// ----- design/asie_exec.sv -----
// ----------------------------------------------------------------------------
// asie_exec
// Decode and execute of one input word: start, load data, branch, data
// processing, load/store address generation, flag update, result fields.
// ----------------------------------------------------------------------------
module asie_exec (
  input  logic [1:0]                   req_i,
  input  logic [asie_pkg::XLEN-1:0]    word_i,
  input  asie_pkg::cfg_t               cfg_i,
  input  logic [asie_pkg::XLEN-1:0]    rn_val_i,
  input  logic [asie_pkg::XLEN-1:0]    rm_val_i,
  input  logic [asie_pkg::XLEN-1:0]    rd_val_i,
  input  logic [asie_pkg::XLEN-1:0]    pc_i,
  input  logic [asie_pkg::XLEN-1:0]    r0_i,
  input  logic [3:0]                   flags_i,
  input  logic                         load_pend_i,
  input  logic [asie_pkg::IDX_W-1:0]   load_dest_i,
  output asie_pkg::rf_wr_t             wr_o,
  output logic [3:0]                   flags_o,
  output logic                         load_pend_o,
  output logic [asie_pkg::IDX_W-1:0]   load_dest_o,
  output asie_pkg::result_t            res_o
);
  import asie_pkg::*;

  function automatic logic cond_holds(input logic [3:0] cond, input logic [3:0] f);
    logic z, n, v;
    z = f[3];
    n = f[2];
    v = f[0];
    case (cond)
      COND_EQ: cond_holds = z;
      COND_NE: cond_holds = !z;
      COND_GE: cond_holds = (n == v);
      COND_LT: cond_holds = (n != v);
      COND_GT: cond_holds = !z && (n == v);
      COND_LE: cond_holds = z || (n != v);
      COND_AL: cond_holds = 1'b1;
      default: cond_holds = 1'b0;
    endcase
  endfunction

  logic [IDX_W-1:0] rd_idx;
  logic [3:0]       opcode;
  logic [XLEN-1:0]  op_b;
  logic [XLEN-1:0]  sum;
  logic [XLEN-1:0]  diff;
  logic [XLEN-1:0]  br_off;
  logic [XLEN-1:0]  pc_plus4;
  logic [XLEN-1:0]  br_target;
  logic [XLEN-1:0]  ls_off;
  logic [XLEN-1:0]  ls_addr;
  logic [3:0]       cmp_flags;
  logic             is_bx;
  logic             is_branch;
  logic             can_exec;
  mem_req_e         mem_req;
  logic [XLEN-1:0]  mem_addr;
  logic [XLEN-1:0]  store_data;
  logic             fault;

  assign rd_idx    = word_i[15:12];
  assign opcode    = word_i[24:21];
  assign op_b      = word_i[25] ? {24'd0, word_i[7:0]} : rm_val_i;
  assign sum       = rn_val_i + op_b;
  assign diff      = rn_val_i - op_b;
  assign br_off    = {{6{word_i[23]}}, word_i[23:0], 2'b00};
  assign pc_plus4  = pc_i + 32'd4;
  assign br_target = pc_i + 32'd8 + br_off;
  assign ls_off    = word_i[25] ? (rm_val_i << word_i[11:7]) : {24'd0, word_i[7:0]};
  assign ls_addr   = rn_val_i + ls_off;
  assign is_bx     = (word_i[27:4] == BX_PATTERN);
  assign is_branch = (word_i[27:25] == BRANCH_CLASS);
  assign can_exec  = !load_pend_i && (pc_i != '0);

  // Borrow-style carry: set when the second operand exceeds the first.
  assign cmp_flags = {(diff == '0), diff[XLEN-1], (op_b > rn_val_i),
                      ((rn_val_i[XLEN-1] ^ op_b[XLEN-1]) &
                       (rn_val_i[XLEN-1] ^ diff[XLEN-1]))};

  always_comb begin
    wr_o        = '0;
    flags_o     = flags_i;
    load_pend_o = load_pend_i;
    load_dest_o = load_dest_i;
    mem_req     = MEM_NONE;
    mem_addr    = '0;
    store_data  = '0;
    fault       = 1'b0;
    case (req_type_e'(req_i))
      REQ_START: begin
        flags_o     = '0;
        load_pend_o = 1'b0;
        load_dest_o = '0;
      end
      REQ_LOAD: begin
        if (load_pend_i) begin
          wr_o.gp_we   = 1'b1;
          wr_o.gp_idx  = load_dest_i;
          wr_o.gp_data = word_i;
          load_pend_o  = 1'b0;
        end
      end
      REQ_INSTR: begin
        if (can_exec) begin
          if (is_bx) begin
            wr_o.pc_we   = 1'b1;
            wr_o.pc_data = rm_val_i;
          end else if (is_branch) begin
            wr_o.pc_we = 1'b1;
            if (cond_holds(word_i[31:28], flags_i)) begin
              wr_o.pc_data = br_target;
              if (word_i[24]) begin
                wr_o.gp_we   = 1'b1;
                wr_o.gp_idx  = LR_IDX;
                wr_o.gp_data = pc_plus4;
              end
            end else begin
              wr_o.pc_data = pc_plus4;
            end
          end else if (word_i[27:26] == CLS_DP) begin
            wr_o.gp_idx = rd_idx;
            case (opcode)
              OP_ADD: begin
                wr_o.gp_we   = 1'b1;
                wr_o.gp_data = sum;
              end
              OP_SUB: begin
                wr_o.gp_we   = 1'b1;
                wr_o.gp_data = diff;
              end
              OP_MOV: begin
                wr_o.gp_we   = 1'b1;
                wr_o.gp_data = op_b;
              end
              OP_CMP:  flags_o = cmp_flags;
              default: ;
            endcase
            // A result written to PC replaces the normal advance.
            wr_o.pc_we   = !(wr_o.gp_we && (rd_idx == PC_IDX));
            wr_o.pc_data = pc_plus4;
          end else if (word_i[27:26] == CLS_LS) begin
            mem_addr     = ls_addr;
            wr_o.pc_data = pc_plus4;
            if (word_i[20]) begin
              mem_req     = MEM_LOAD;
              load_pend_o = 1'b1;
              load_dest_o = rd_idx;
              // A load into PC holds PC until the data word arrives.
              wr_o.pc_we  = (rd_idx != PC_IDX);
            end else begin
              mem_req    = MEM_STORE;
              store_data = rd_val_i;
              wr_o.pc_we = 1'b1;
            end
          end else begin
            fault = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_o            = '0;
    res_o.mem_req    = mem_req;
    res_o.mem_addr   = mem_addr;
    res_o.store_data = store_data;
    res_o.fault      = fault;
    res_o.flags      = flags_o;
    if (req_type_e'(req_i) == REQ_START) begin
      res_o.next_pc = cfg_i.entry_pc;
      res_o.ret_val = cfg_i.arg_zero;
    end else begin
      if (wr_o.pc_we) begin
        res_o.next_pc = wr_o.pc_data;
      end else if (wr_o.gp_we && (wr_o.gp_idx == PC_IDX)) begin
        res_o.next_pc = wr_o.gp_data;
      end else begin
        res_o.next_pc = pc_i;
      end
      if (wr_o.gp_we && (wr_o.gp_idx == '0)) begin
        res_o.ret_val = wr_o.gp_data;
      end else begin
        res_o.ret_val = r0_i;
      end
    end
  end

endmodule

// ----- design/asie_checker.sv -----
// ----------------------------------------------------------------------------
// asie_checker
// Port-level checks on the result stream of the executor, bound to the top.
// ----------------------------------------------------------------------------
`include "arm_subset_instruction_executor_assert.svh"

module asie_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [asie_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]                       m_axis_tuser
);
  import asie_pkg::*;

  logic [XLEN-1:0] out_pc;
  logic [XLEN-1:0] out_addr;
  logic [XLEN-1:0] out_sdata;
  logic            out_done;
  logic            out_fault;

  assign out_pc    = m_axis_tdata[OUT_PC_LSB +: XLEN];
  assign out_addr  = m_axis_tdata[OUT_ADDR_LSB +: XLEN];
  assign out_sdata = m_axis_tdata[OUT_SDATA_LSB +: XLEN];
  assign out_done  = m_axis_tdata[OUT_DONE_BIT];
  assign out_fault = m_axis_tdata[OUT_FAULT_BIT];

  // The done flag tracks a zero next PC in every word.
  `ASIE_ASSERT_NOW(a_done_pc, clk_i, rst_ni, m_axis_tvalid, out_done == (out_pc == '0), "done flag disagrees with next PC")

  // A faulting instruction issues no memory access.
  `ASIE_ASSERT_NOW(a_fault_no_mem, clk_i, rst_ni, m_axis_tvalid && out_fault, (m_axis_tuser == MEM_NONE) && (out_addr == '0), "fault word carries a memory request")

  // Store data only appears with a store, and an address only with an access.
  `ASIE_ASSERT_NOW(a_mem_fields, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser != MEM_STORE), (out_sdata == '0) && ((m_axis_tuser != MEM_NONE) || (out_addr == '0)), "memory fields set without a matching request")

  // A stalled result word holds until it is taken.
  `ASIE_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result word changed")

endmodule

bind arm_subset_instruction_executor asie_checker u_asie_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
